>>> rtl/tcw_pkg.sv
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [15:0]       cell_t;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_SET   = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] RESET_COLOR  = 8'h0F;
	localparam logic [3:0] RESET_FG     = 4'd15;
	localparam logic [3:0] RESET_BG     = 4'd0;

	localparam logic [0:0] REG_FG = 1'b0;
	localparam logic [0:0] REG_BG = 1'b1;

	localparam logic [6:0] COL_END  = 7'(COLUMNS);
	localparam logic [4:0] ROW_END  = 5'(ROWS);
	localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);

	localparam addr_t ADDR_LAST     = ADDR_W'(CELL_COUNT - 1);
	localparam addr_t ROW_STRIDE    = ADDR_W'(COLUMNS);
	localparam addr_t LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);

	typedef struct packed {
		logic  en;
		addr_t addr;
		cell_t data;
	} ram_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} ram_rd_t;

	typedef struct packed {
		logic       valid;
		logic [6:0] col;
		logic [4:0] row;
		logic [7:0] ch;
		logic [7:0] color;
	} result_t;

	function automatic addr_t cell_addr(logic [4:0] row, logic [6:0] col);
		cell_addr = ADDR_W'(int'(row) * COLUMNS + int'(col));
	endfunction

endpackage

>>> rtl/tcw_item_if.sv
interface tcw_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_code;
	logic [6:0] target_col;
	logic [4:0] target_row;

	modport source(output valid, kind, char_code, target_col, target_row, input ready);
	modport sink(input valid, kind, char_code, target_col, target_row, output ready);
endinterface

>>> rtl/tcw_result_if.sv
interface tcw_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic [7:0] cell_char;
	logic [7:0] cell_color;

	modport source(output valid, cursor_col, cursor_row, cell_char, cell_color, input ready);
	modport sink(input valid, cursor_col, cursor_row, cell_char, cell_color, output ready);
endinterface

>>> rtl/tcw_cell_ram.sv
module tcw_cell_ram (
	input  logic             clk,
	input  tcw_pkg::ram_wr_t wr,
	input  tcw_pkg::ram_rd_t rd,
	output tcw_pkg::cell_t   rdata
);
	import tcw_pkg::*;

	cell_t mem [CELL_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

>>> rtl/tcw_seq.sv
module tcw_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       kind,
	input  logic [7:0]       char_code,
	input  logic [6:0]       target_col,
	input  logic [4:0]       target_row,
	input  logic [3:0]       fg,
	input  logic [3:0]       bg,
	input  logic             out_free,
	output logic             idle,
	output tcw_pkg::result_t done,
	output tcw_pkg::ram_wr_t wr,
	output tcw_pkg::ram_rd_t rd,
	input  tcw_pkg::cell_t   rdata
);
	import tcw_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_BLANK  = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;
	localparam logic [2:0] ST_PUTC   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	localparam logic [1:0] SRC_DATA = 2'd0;
	localparam logic [1:0] SRC_COPY = 2'd1;
	localparam logic [1:0] SRC_BKSP = 2'd2;

	logic [2:0] state_q;
	logic       pend_q;
	logic       putc_q;
	logic       hit_q;
	logic [1:0] kind_q;
	logic [7:0] ch_q;
	logic [6:0] tcol_q;
	logic [4:0] trow_q;
	logic [6:0] col_q;
	logic [4:0] row_q;
	addr_t      addr_q;
	cell_t      fill_q;

	logic       wr_en_s1;
	addr_t      wr_addr_s1;
	logic [1:0] wr_src_s1;
	cell_t      wr_data_s1;

	logic [7:0] color;
	cell_t      blank;
	logic       is_nl;
	logic       is_bs;
	logic       wrap;
	logic       last_row;
	logic       in_range;

	assign color    = {bg, fg};
	assign blank    = {color, CH_SPACE};
	assign is_nl    = (ch_q == CH_NEWLINE);
	assign is_bs    = (ch_q == CH_BACKSPACE);
	assign wrap     = (col_q >= COL_END);
	assign last_row = (row_q == ROW_LAST);
	assign in_range = (tcol_q < COL_END) && (trow_q < ROW_END);
	assign idle     = (state_q == ST_IDLE);

	always_comb begin
		rd.en   = 1'b0;
		rd.addr = '0;
		case (state_q)
			ST_EXEC: begin
				if (kind_q == KIND_PUT && is_bs && col_q != 7'd0) begin
					rd.en   = 1'b1;
					rd.addr = cell_addr(row_q, col_q - 7'd1);
				end else if (kind_q == KIND_READ && in_range) begin
					rd.en   = 1'b1;
					rd.addr = cell_addr(trow_q, tcol_q);
				end
			end
			ST_SCROLL: begin
				rd.en   = 1'b1;
				rd.addr = addr_q;
			end
			default: begin
				rd.en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr.en   = wr_en_s1;
		wr.addr = wr_addr_s1;
		case (wr_src_s1)
			SRC_COPY: wr.data = rdata;
			SRC_BKSP: wr.data = {rdata[15:8], CH_SPACE};
			default:  wr.data = wr_data_s1;
		endcase
	end

	always_comb begin
		done.valid = (state_q == ST_DONE) && pend_q;
		done.col   = col_q;
		done.row   = row_q;
		if (kind_q == KIND_READ && hit_q) begin
			done.ch    = rdata[7:0];
			done.color = rdata[15:8];
		end else begin
			done.ch    = 8'd0;
			done.color = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			addr_q   <= '0;
			fill_q   <= {RESET_COLOR, CH_SPACE};
			pend_q   <= 1'b0;
			putc_q   <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						ch_q    <= char_code;
						tcol_q  <= target_col;
						trow_q  <= target_row;
						pend_q  <= 1'b1;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (kind_q)
						KIND_PUT: begin
							if (is_nl) begin
								col_q <= '0;
								if (!last_row) begin
									row_q <= row_q + 5'd1;
								end else begin
									addr_q  <= ROW_STRIDE;
									putc_q  <= 1'b0;
									state_q <= ST_SCROLL;
								end
							end else if (is_bs) begin
								if (col_q != 7'd0) begin
									col_q      <= col_q - 7'd1;
									wr_en_s1   <= 1'b1;
									wr_addr_s1 <= cell_addr(row_q, col_q - 7'd1);
									wr_src_s1  <= SRC_BKSP;
								end
							end else if (wrap && last_row) begin
								col_q   <= 7'd1;
								addr_q  <= ROW_STRIDE;
								putc_q  <= 1'b1;
								state_q <= ST_SCROLL;
							end else begin
								wr_en_s1   <= 1'b1;
								wr_src_s1  <= SRC_DATA;
								wr_data_s1 <= {color, ch_q};
								if (wrap) begin
									wr_addr_s1 <= cell_addr(row_q + 5'd1, 7'd0);
									row_q      <= row_q + 5'd1;
									col_q      <= 7'd1;
								end else begin
									wr_addr_s1 <= cell_addr(row_q, col_q);
									col_q      <= col_q + 7'd1;
								end
							end
						end
						KIND_CLEAR: begin
							fill_q  <= blank;
							addr_q  <= '0;
							col_q   <= '0;
							row_q   <= '0;
							state_q <= ST_FILL;
						end
						KIND_SET: begin
							if (in_range) begin
								col_q <= tcol_q;
								row_q <= trow_q;
							end
						end
						default: begin
							hit_q <= in_range;
						end
					endcase
				end
				ST_SCROLL: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= addr_q - ROW_STRIDE;
					wr_src_s1  <= SRC_COPY;
					if (addr_q == ADDR_LAST) begin
						addr_q  <= LAST_ROW_BASE;
						state_q <= ST_BLANK;
					end else begin
						addr_q <= addr_q + addr_t'(1);
					end
				end
				ST_BLANK: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= addr_q;
					wr_src_s1  <= SRC_DATA;
					wr_data_s1 <= blank;
					if (addr_q == ADDR_LAST) begin
						state_q <= putc_q ? ST_PUTC : ST_DONE;
					end else begin
						addr_q <= addr_q + addr_t'(1);
					end
				end
				ST_FILL: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= addr_q;
					wr_src_s1  <= SRC_DATA;
					wr_data_s1 <= fill_q;
					if (addr_q == ADDR_LAST) begin
						state_q <= ST_DONE;
					end else begin
						addr_q <= addr_q + addr_t'(1);
					end
				end
				ST_PUTC: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= LAST_ROW_BASE;
					wr_src_s1  <= SRC_DATA;
					wr_data_s1 <= {color, ch_q};
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (!pend_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/text_console_writer_core.sv
// Channel   Direction  Contents
// item      in         kind, char_code, target_col, target_row
// result    out        cursor_col, cursor_row, cell_char, cell_color
// config    in         cfg_we, cfg_index, cfg_wdata (fg_color, bg_color)
//
// One word is worked on at a time; set, read, backspace, plain characters that do not
// wrap off the bottom row and a newline above the bottom row pass from acceptance
// through the EXEC and DONE states to the output register, and item is ready again
// once the sequencer is back in idle. A scroll or a clear sweeps the cell memory one
// cell per cycle over all 2000 cells. After reset a fill pass writes spaces into all
// 2000 cells before item goes ready. A stalled result holds in the output register while
// the next word is accepted; that word then waits for the register to free up.
module text_console_writer_core (
	input  logic       clk,
	input  logic       arst_n,
	tcw_item_if.sink   item,
	tcw_result_if.source result,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [3:0] cfg_wdata
);
	import tcw_pkg::*;

	logic [3:0] fg_color_q;
	logic [3:0] bg_color_q;
	logic       res_valid_q;
	result_t    res_q;
	result_t    done;
	logic       out_free;
	logic       idle;
	ram_wr_t    wr;
	ram_rd_t    rd;
	cell_t      rdata;

	assign out_free   = !res_valid_q || result.ready;
	assign item.ready = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= RESET_FG;
			bg_color_q <= RESET_BG;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FG:  fg_color_q <= cfg_wdata;
				REG_BG:  bg_color_q <= cfg_wdata;
				default: fg_color_q <= fg_color_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done.valid && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid && out_free) begin
			res_q <= done;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.cursor_col = res_q.col;
	assign result.cursor_row = res_q.row;
	assign result.cell_char  = res_q.ch;
	assign result.cell_color = res_q.color;

	tcw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (item.valid && idle),
		.kind       (item.kind),
		.char_code  (item.char_code),
		.target_col (item.target_col),
		.target_row (item.target_row),
		.fg         (fg_color_q),
		.bg         (bg_color_q),
		.out_free   (out_free),
		.idle       (idle),
		.done       (done),
		.wr         (wr),
		.rd         (rd),
		.rdata      (rdata)
	);

	tcw_cell_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

endmodule

>>> rtl/tcw_checker.sv
module tcw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [6:0] cursor_col,
	input logic [4:0] cursor_row
);
	import tcw_pkg::*;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cursor_col <= COL_END)
		else $error("cursor column beyond the line end");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cursor_row < ROW_END)
		else $error("cursor row beyond the last row");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in flight");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(cursor_col) && $stable(cursor_row))
		else $error("stalled result changed");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.cursor_col   (result.cursor_col),
	.cursor_row   (result.cursor_row)
);
